// ===== hdl/nwt_pkg.sv =====
// Types, codes and character classes for the number/whitespace tokenizer.
// No dependencies; every other file in hdl/ imports this package.
package nwt_pkg;

  localparam int FIELD_BITS = 16;
  localparam int FIFO_DEPTH = 4;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_B   = 8'h62;
  localparam logic [7:0] CHAR_O   = 8'h6f;
  localparam logic [7:0] CHAR_X   = 8'h78;
  localparam logic [7:0] CHAR_DOT = 8'h2e;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_WS,
    MODE_ZERO,
    MODE_INT,
    MODE_FRAC,
    MODE_BIN,
    MODE_OCT,
    MODE_HEX,
    MODE_TAIL
  } scan_mode_t;

  typedef enum logic [2:0] {
    KIND_EOF,
    KIND_BAD_CHAR,
    KIND_WS,
    KIND_NUMBER,
    KIND_BAD_NUMBER
  } token_kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    token_kind_t           token_kind;
    logic [FIELD_BITS-1:0] start_offset;
    logic [FIELD_BITS-1:0] end_offset;
    logic [FIELD_BITS-1:0] start_line;
    logic [FIELD_BITS-1:0] start_column;
    logic                  last;
  } token_item_t;

  typedef struct packed {
    logic [1:0]  count;
    token_item_t first;
    token_item_t second;
  } push_t;

  typedef struct packed {
    logic not_empty;
    logic room_for_two;
  } fifo_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  function automatic logic is_ws_start(input logic [7:0] c);
    return (c == 8'h20) || (c == CHAR_LF) || (c == 8'h0d) || (c == 8'h09);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_tail(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CHAR_DOT);
  endfunction

endpackage

// ===== hdl/nwt_if.sv =====
// Valid/ready channel interfaces for text bytes in and tokens out.
// Depends on nwt_pkg for the item types.
interface nwt_text_if;
  import nwt_pkg::*;
  logic       valid;
  logic       ready;
  text_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nwt_token_if;
  import nwt_pkg::*;
  logic        valid;
  logic        ready;
  token_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/number_whitespace_tokenizer_unit.sv =====
// Number/whitespace tokenizer top level. Depends on nwt_pkg, nwt_if, nwt_result_fifo.
// Tokens closed by an item are registered in the result queue and reach the output port from its head.
// Throughput: one byte per cycle while the result queue has two free slots; an item that closes
// two tokens gives them out one at a time, absorbed by the four-entry result queue (input ready needs two free slots).
// Reset (synchronous, rst high): line register 1, counters and queue cleared,
// no token open.
module number_whitespace_tokenizer_unit #(
  parameter int OFFSET_BITS = 16,
  parameter int LINE_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  nwt_text_if.sink             text,
  nwt_token_if.source          token
);
  import nwt_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

  logic [15:0]            first_line_number;
  scan_mode_t             scan_mode, scan_mode_next;
  logic [OFFSET_BITS-1:0] cur_offset, cur_offset_next;
  logic [LINE_BITS-1:0]   cur_line, cur_line_next;
  logic [OFFSET_BITS-1:0] cur_column, cur_column_next;
  logic [OFFSET_BITS-1:0] tok_offset, tok_offset_next;
  logic [LINE_BITS-1:0]   tok_line, tok_line_next;
  logic [OFFSET_BITS-1:0] tok_column, tok_column_next;

  logic                   accept;
  logic [7:0]             c;
  logic                   eot;
  logic                   open;
  scan_mode_t             ext_mode;
  logic [OFFSET_BITS-1:0] adv_offset;
  logic [LINE_BITS-1:0]   adv_line;
  logic [OFFSET_BITS-1:0] adv_column;
  logic [LINE_BITS-1:0]   reg_line, cfg_line;
  token_item_t            pend_tok, eof_tok, bad_tok;
  push_t                  push;
  fifo_status_t           status;
  token_item_t            head;

  function automatic logic [LINE_BITS-1:0] sat_line(input logic [15:0] v);
    return (32'(v) > 32'(LINE_MAX)) ? LINE_MAX : LINE_BITS'(v);
  endfunction

  function automatic scan_mode_t extend(input scan_mode_t m, input logic [7:0] ch);
    scan_mode_t r;
    r = is_tail(ch) ? MODE_TAIL : MODE_IDLE;
    unique case (m)
      MODE_WS:   r = is_space(ch) ? MODE_WS : MODE_IDLE;
      MODE_ZERO: begin
        if (ch == CHAR_B) r = MODE_BIN;
        else if (ch == CHAR_O) r = MODE_OCT;
        else if (ch == CHAR_X) r = MODE_HEX;
        else if (is_digit(ch)) r = MODE_INT;
        else if (ch == CHAR_DOT) r = MODE_FRAC;
      end
      MODE_INT: begin
        if (is_digit(ch)) r = MODE_INT;
        else if (ch == CHAR_DOT) r = MODE_FRAC;
      end
      MODE_FRAC: if (is_digit(ch)) r = MODE_FRAC;
      MODE_BIN:  if ((ch == 8'h30) || (ch == 8'h31)) r = MODE_BIN;
      MODE_OCT:  if ((ch >= 8'h30) && (ch <= 8'h37)) r = MODE_OCT;
      MODE_HEX:  if (is_hex(ch)) r = MODE_HEX;
      MODE_TAIL: r = is_tail(ch) ? MODE_TAIL : MODE_IDLE;
      default:   r = MODE_IDLE;
    endcase
    return r;
  endfunction

  function automatic token_kind_t pending_kind(input scan_mode_t m);
    token_kind_t k;
    case (m)
      MODE_WS:   k = KIND_WS;
      MODE_TAIL: k = KIND_BAD_NUMBER;
      default:   k = KIND_NUMBER;
    endcase
    return k;
  endfunction

  assign accept   = text.valid & text.ready;
  assign c        = text.data.text_byte;
  assign eot      = text.data.end_of_text | (c == CHAR_NUL);
  assign open     = (scan_mode != MODE_IDLE);
  assign ext_mode = eot ? MODE_IDLE : extend(scan_mode, c);
  assign reg_line = sat_line(first_line_number);
  assign cfg_line = sat_line(cfg_wr_data);

  assign adv_offset = (cur_offset == OFF_MAX) ? cur_offset : cur_offset + 1'b1;
  assign adv_line   = ((c == CHAR_LF) && (cur_line != LINE_MAX)) ? cur_line + 1'b1 : cur_line;
  assign adv_column = (c == CHAR_LF) ? '0 :
                      (cur_column == OFF_MAX) ? cur_column : cur_column + 1'b1;

  always_comb begin
    pend_tok.token_kind   = pending_kind(scan_mode);
    pend_tok.start_offset = 16'(tok_offset);
    pend_tok.end_offset   = 16'(cur_offset);
    pend_tok.start_line   = 16'(tok_line);
    pend_tok.start_column = 16'(tok_column);
    pend_tok.last         = 1'b0;

    eof_tok.token_kind    = KIND_EOF;
    eof_tok.start_offset  = 16'(cur_offset);
    eof_tok.end_offset    = 16'(cur_offset);
    eof_tok.start_line    = 16'(cur_line);
    eof_tok.start_column  = 16'(cur_column);
    eof_tok.last          = 1'b1;

    bad_tok.token_kind    = KIND_BAD_CHAR;
    bad_tok.start_offset  = 16'(cur_offset);
    bad_tok.end_offset    = 16'(adv_offset);
    bad_tok.start_line    = 16'(cur_line);
    bad_tok.start_column  = 16'(cur_column);
    bad_tok.last          = 1'b1;
  end

  always_comb begin
    scan_mode_next  = scan_mode;
    cur_offset_next = cur_offset;
    cur_line_next   = cur_line;
    cur_column_next = cur_column;
    tok_offset_next = tok_offset;
    tok_line_next   = tok_line;
    tok_column_next = tok_column;
    push            = '0;

    if (accept) begin
      if (open && (ext_mode != MODE_IDLE)) begin
        scan_mode_next  = ext_mode;
        cur_offset_next = adv_offset;
        cur_line_next   = adv_line;
        cur_column_next = adv_column;
      end else begin
        scan_mode_next = MODE_IDLE;
        if (eot) begin
          cur_offset_next = '0;
          cur_line_next   = reg_line;
          cur_column_next = '0;
          tok_offset_next = '0;
          tok_line_next   = reg_line;
          tok_column_next = '0;
          if (open) begin
            push.count  = 2'd2;
            push.first  = pend_tok;
            push.second = eof_tok;
          end else begin
            push.count = 2'd1;
            push.first = eof_tok;
          end
        end else begin
          tok_offset_next = cur_offset;
          tok_line_next   = cur_line;
          tok_column_next = cur_column;
          cur_offset_next = adv_offset;
          cur_line_next   = adv_line;
          cur_column_next = adv_column;
          if (is_ws_start(c)) begin
            scan_mode_next = MODE_WS;
          end else if (is_digit(c)) begin
            scan_mode_next = (c == 8'h30) ? MODE_ZERO : MODE_INT;
          end
          if (!is_ws_start(c) && !is_digit(c)) begin
            if (open) begin
              push.count  = 2'd2;
              push.first  = pend_tok;
              push.second = bad_tok;
            end else begin
              push.count = 2'd1;
              push.first = bad_tok;
            end
          end else if (open) begin
            push.count      = 2'd1;
            push.first      = pend_tok;
            push.first.last = 1'b1;
          end
        end
      end
    end

    if (cfg_wr_en && (cur_offset == '0)) begin
      cur_line_next = cfg_line;
      tok_line_next = cfg_line;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_line_number <= 16'd1;
      scan_mode         <= MODE_IDLE;
      cur_offset        <= '0;
      cur_line          <= LINE_BITS'(1);
      cur_column        <= '0;
      tok_offset        <= '0;
      tok_line          <= LINE_BITS'(1);
      tok_column        <= '0;
    end else begin
      if (cfg_wr_en) begin
        first_line_number <= cfg_wr_data;
      end
      scan_mode  <= scan_mode_next;
      cur_offset <= cur_offset_next;
      cur_line   <= cur_line_next;
      cur_column <= cur_column_next;
      tok_offset <= tok_offset_next;
      tok_line   <= tok_line_next;
      tok_column <= tok_column_next;
    end
  end

  nwt_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (token.valid & token.ready),
    .head   (head),
    .status (status)
  );

  assign text.ready  = status.room_for_two;
  assign token.valid = status.not_empty;
  assign token.data  = head;

  a_eot_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && eot && !cfg_wr_en) |=> (scan_mode == MODE_IDLE) && (cur_offset == '0))
    else $error("end of text did not restart counters");

  a_offset_step: assert property (@(posedge clk) disable iff (rst)
    (accept && !eot) |=>
      (cur_offset == (($past(cur_offset) == OFF_MAX) ? OFF_MAX : $past(cur_offset) + 1'b1)))
    else $error("offset did not advance on byte");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |->
      (push.first.token_kind != KIND_EOF) && !push.first.last && push.second.last)
    else $error("bad ordering of paired tokens");

endmodule

// ===== hdl/nwt_result_fifo.sv =====
// Result queue: takes zero, one or two tokens a cycle, gives one.
// Depends on nwt_pkg.
module nwt_result_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  nwt_pkg::push_t         push,
  input  logic                   pop,
  output nwt_pkg::token_item_t   head,
  output nwt_pkg::fifo_status_t  status
);
  import nwt_pkg::*;

  localparam int PTR_BITS = $clog2(FIFO_DEPTH);

  token_item_t         entries [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push.count);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      count  <= count + (PTR_BITS+1)'(push.count) - (PTR_BITS+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[PTR_BITS'(wr_ptr + 1'b1)] <= push.second;
    end
  end

  assign head                = entries[rd_ptr];
  assign status.not_empty    = (count != '0);
  assign status.room_for_two = (count <= (PTR_BITS+1)'(FIFO_DEPTH - 2));

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PTR_BITS+1)'(FIFO_DEPTH))
    else $error("result queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> status.room_for_two)
    else $error("push without room");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && push.count == 2'd0) |=> (count == $past(count) - 1'b1))
    else $error("pop did not drop count");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench for number_whitespace_tokenizer_unit: drives text bytes, predicts tokens
// with its own tokenizer model and checks each token field. Needs nwt_pkg, nwt_if, hdl/.
module tb;
  import nwt_pkg::*;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [15:0] COUNT_MAX = 16'hffff;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int LONG_TEXT_BYTES = 60;
  localparam int RANDOM_ITEMS = 600;
  localparam int CHUNK_ITEMS = 90;
  localparam int MAX_PRINTED = 40;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [15:0] cfg_wr_data;

  nwt_text_if text_ch ();
  nwt_token_if token_ch ();

  number_whitespace_tokenizer_unit i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .text(text_ch),
    .token(token_ch)
  );

  text_item_t pending_items[$];
  token_item_t expected_tokens[$];
  int items_issued = 0;
  int items_taken = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  bit text_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int pattern_age = 0;
  logic [15:0] ready_pattern = '1;

  scan_mode_t scan_mode;
  logic [15:0] first_line;
  logic [15:0] cur_offset;
  logic [15:0] cur_line;
  logic [15:0] cur_column;
  logic [15:0] tok_offset;
  logic [15:0] tok_line;
  logic [15:0] tok_column;

  function automatic bit digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter_byte(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit space_byte(logic [7:0] c);
    return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit ws_opener(logic [7:0] c);
    return c == CH_SP || c == CHAR_LF || c == CH_CR || c == CH_TAB;
  endfunction

  function automatic bit hex_byte(logic [7:0] c);
    return digit_byte(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit tail_byte(logic [7:0] c);
    return letter_byte(c) || digit_byte(c) || c == CHAR_DOT;
  endfunction

  function automatic scan_mode_t grow_mode(scan_mode_t m, logic [7:0] c);
    case (m)
      MODE_WS: return space_byte(c) ? MODE_WS : MODE_IDLE;
      MODE_ZERO: begin
        if (c == CHAR_B) return MODE_BIN;
        if (c == CHAR_O) return MODE_OCT;
        if (c == CHAR_X) return MODE_HEX;
        if (digit_byte(c)) return MODE_INT;
        if (c == CHAR_DOT) return MODE_FRAC;
      end
      MODE_INT: begin
        if (digit_byte(c)) return MODE_INT;
        if (c == CHAR_DOT) return MODE_FRAC;
      end
      MODE_FRAC: if (digit_byte(c)) return MODE_FRAC;
      MODE_BIN: if (c == "0" || c == "1") return MODE_BIN;
      MODE_OCT: if (c >= "0" && c <= "7") return MODE_OCT;
      MODE_HEX: if (hex_byte(c)) return MODE_HEX;
      MODE_TAIL: ;
      default: return MODE_IDLE;
    endcase
    return tail_byte(c) ? MODE_TAIL : MODE_IDLE;
  endfunction

  function automatic token_kind_t open_kind(scan_mode_t m);
    if (m == MODE_WS) return KIND_WS;
    if (m == MODE_TAIL) return KIND_BAD_NUMBER;
    return KIND_NUMBER;
  endfunction

  function automatic token_item_t make_token(token_kind_t kind, logic [15:0] from,
                                             logic [15:0] upto, logic [15:0] line,
                                             logic [15:0] col);
    token_item_t t;
    t.token_kind = kind;
    t.start_offset = from;
    t.end_offset = upto;
    t.start_line = line;
    t.start_column = col;
    t.last = 1'b0;
    return t;
  endfunction

  task automatic restart_text();
    scan_mode = MODE_IDLE;
    cur_offset = '0;
    cur_line = first_line;
    cur_column = '0;
    tok_offset = '0;
    tok_line = first_line;
    tok_column = '0;
  endtask

  task automatic advance_counters(input logic [7:0] c);
    if (cur_offset != COUNT_MAX) cur_offset++;
    if (c == CHAR_LF) begin
      if (cur_line != COUNT_MAX) cur_line++;
      cur_column = '0;
    end else if (cur_column != COUNT_MAX) begin
      cur_column++;
    end
  endtask

  task automatic predict_tokens(input text_item_t it);
    token_item_t found[2];
    int n;
    logic [7:0] c;
    bit eot;
    scan_mode_t nxt;
    n = 0;
    c = it.text_byte;
    eot = it.end_of_text || c == CHAR_NUL;
    if (scan_mode != MODE_IDLE) begin
      nxt = eot ? MODE_IDLE : grow_mode(scan_mode, c);
      if (nxt != MODE_IDLE) begin
        scan_mode = nxt;
        advance_counters(c);
        return;
      end
      found[n] = make_token(open_kind(scan_mode), tok_offset, cur_offset, tok_line, tok_column);
      n++;
      scan_mode = MODE_IDLE;
    end
    if (eot) begin
      found[n] = make_token(KIND_EOF, cur_offset, cur_offset, cur_line, cur_column);
      n++;
      restart_text();
    end else begin
      tok_offset = cur_offset;
      tok_line = cur_line;
      tok_column = cur_column;
      advance_counters(c);
      if (ws_opener(c)) begin
        scan_mode = MODE_WS;
      end else if (digit_byte(c)) begin
        scan_mode = (c == "0") ? MODE_ZERO : MODE_INT;
      end else begin
        found[n] = make_token(KIND_BAD_CHAR, tok_offset, cur_offset, tok_line, tok_column);
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) found[i].last = 1'b1;
      expected_tokens.push_back(found[i]);
    end
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic check_token(input token_item_t got);
    token_item_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch($sformatf("unexpected token kind %0d at offset %0d",
                                got.token_kind, got.start_offset));
    end else begin
      want = expected_tokens.pop_front();
      compare_field("token_kind", 16'(got.token_kind), 16'(want.token_kind));
      compare_field("start_offset", got.start_offset, want.start_offset);
      compare_field("end_offset", got.end_offset, want.end_offset);
      compare_field("start_line", got.start_line, want.start_line);
      compare_field("start_column", got.start_column, want.start_column);
      compare_field("last", 16'(got.last), 16'(want.last));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    text_taken = 1'b0;
    if (!rst) begin
      if (token_ch.valid && token_ch.ready) check_token(token_ch.data);
      text_taken = text_ch.valid && text_ch.ready;
      if (text_taken) begin
        items_taken++;
        predict_tokens(text_ch.data);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      text_ch.valid <= 1'b0;
    end else if (!text_ch.valid || text_taken) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        if (gap_left > 0) gap_left--;
        text_ch.valid <= 1'b0;
      end else begin
        text_ch.valid <= 1'b1;
        text_ch.data <= pending_items.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (pattern_age == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = '1;
        1: ready_pattern = 16'($urandom) | 16'h0001;
        2: ready_pattern = 16'h0101;
        default: ready_pattern = 16'h0001;
      endcase
      pattern_age = $urandom_range(8, 80);
    end
    pattern_age--;
    token_ch.ready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
  end

  task automatic push_item(input logic [7:0] b, input bit eot);
    text_item_t it;
    it.text_byte = b;
    it.end_of_text = eot;
    pending_items.push_back(it);
    items_issued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endtask

  task automatic push_end_of_text();
    if ($urandom_range(0, 2) == 0) push_item(CHAR_NUL, 1'($urandom_range(0, 1)));
    else push_item(8'($urandom), 1'b1);
  endtask

  function automatic logic [7:0] pick_from(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // in_line keeps the text on one line; may_end allows end-of-text items
  task automatic push_random_token(input bit in_line, input bit may_end);
    int len;
    logic [7:0] b;
    case ($urandom_range(0, 11))
      0, 1: begin
        push_item(pick_from(in_line ? " \015\t" : " \n\015\t"), 1'b0);
        len = $urandom_range(0, 4);
        repeat (len) push_item(pick_from(in_line ? " \015\t\v\f" : " \n\015\t\v\f"), 1'b0);
      end
      2: begin
        len = $urandom_range(1, 5);
        repeat (len) push_item(pick_from("0123456789"), 1'b0);
      end
      3: begin
        len = $urandom_range(1, 3);
        repeat (len) push_item(pick_from("0123456789"), 1'b0);
        push_item(CHAR_DOT, 1'b0);
        len = $urandom_range(0, 3);
        repeat (len) push_item(pick_from("0123456789"), 1'b0);
      end
      4, 5: begin
        push_item("0", 1'b0);
        len = $urandom_range(0, 4);
        case ($urandom_range(0, 2))
          0: begin
            push_item(CHAR_B, 1'b0);
            repeat (len) push_item(pick_from("01"), 1'b0);
          end
          1: begin
            push_item(CHAR_O, 1'b0);
            repeat (len) push_item(pick_from("01234567"), 1'b0);
          end
          default: begin
            push_item(CHAR_X, 1'b0);
            repeat (len) push_item(pick_from("0123456789abcdefABCDEF"), 1'b0);
          end
        endcase
      end
      6: begin
        len = $urandom_range(1, 2);
        repeat (len) push_item(pick_from("0123456789"), 1'b0);
        len = $urandom_range(1, 3);
        repeat (len) push_item(pick_from("gzGZ.9bxo"), 1'b0);
      end
      7: begin
        do b = 8'($urandom_range(1, 255)); while (digit_byte(b) || ws_opener(b));
        push_item(b, 1'b0);
      end
      8: begin
        b = 8'($urandom_range(1, 255));
        if (in_line && b == CHAR_LF) b = CH_SP;
        push_item(b, 1'b0);
      end
      9: begin
        push_item("0", 1'b0);
        if ($urandom_range(0, 1) == 0) push_item(CHAR_DOT, 1'b0);
      end
      default: begin
        if (may_end) push_end_of_text();
        else push_item(",", 1'b0);
      end
    endcase
  endtask

  task automatic wait_drained();
    while (items_taken != items_issued || expected_tokens.size() != 0) @(negedge clk);
  endtask

  task automatic write_first_line(input logic [15:0] value);
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    first_line = value;
    if (cur_offset == 0) begin
      cur_line = value;
      tok_line = value;
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int chunk_start;
    int random_start;
    int chunk_index;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    text_ch.valid = 1'b0;
    text_ch.data = '0;
    token_ch.ready = 1'b0;
    first_line = 16'd1;
    restart_text();
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    push_text(" \v\n0x1F 0b,0o17\t12.5\v");
    push_item(8'hc3, 1'b0);
    push_text("3a9");
    push_item(CHAR_NUL, 1'b0);
    wait_drained();
    write_first_line(16'hfffe);
    push_text("7.\n0b1 \n");
    push_item(8'h5a, 1'b1);
    wait_drained();
    write_first_line(16'd0);

    random_start = items_issued;
    chunk_index = 0;
    while (items_issued < random_start + RANDOM_ITEMS) begin
      chunk_start = items_issued;
      while (items_issued < chunk_start + CHUNK_ITEMS) push_random_token(1'b0, 1'b1);
      wait_drained();
      chunk_index++;
      case (chunk_index % 4)
        0: write_first_line(COUNT_MAX);
        1: write_first_line(16'($urandom));
        2: write_first_line(16'd1);
        default: write_first_line(16'($urandom_range(0, 15)));
      endcase
    end

    // finish with a text whose random part stays on one line, then a newline, 0x7 and q, then close it
    push_end_of_text();
    chunk_start = items_issued;
    while (items_issued < chunk_start + LONG_TEXT_BYTES) push_random_token(1'b1, 1'b0);
    push_text("\n0x7 q");
    push_end_of_text();
    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/nwt_pkg.sv
hdl/nwt_if.sv
hdl/nwt_result_fifo.sv
hdl/number_whitespace_tokenizer_unit.sv
sim/tb.sv
